// File: hdl/fhtc_pkg.sv
`default_nettype none

package fhtc_pkg;

    // defaults for the top level parameters
    localparam int DEFAULT_MAX_TRIANGLES = 8;
    localparam int DEFAULT_COORD_BITS    = 12;

    // fixed field widths
    localparam int OP_BITS       = 2;
    localparam int TRI_BITS      = 3;
    localparam int SLOT_BITS     = 2;
    localparam int CHAN_BITS     = 8;
    localparam int COLOR_BITS    = 3 * CHAN_BITS;
    localparam int HIT_BITS      = 3;
    localparam int OFFSET_BITS   = 10;
    localparam int COUNT_BITS    = 4;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 10;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_LOAD_VERTEX = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_COLOR  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY       = 2'd2;

    // vertex slot code that writes nothing
    localparam logic [SLOT_BITS-1:0] SLOT_UNUSED = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_OFFSET = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TRIS_IN_USE   = 1'd1;

    // register reset values
    localparam logic [OFFSET_BITS-1:0] CENTER_OFFSET_RESET = 10'd250;
    localparam logic [COUNT_BITS-1:0]  TRIS_IN_USE_RESET   = 4'd6;

    // width of a centered coordinate: holds column minus offset and offset minus row
    function automatic int point_bits(input int coord_bits);
        return ((coord_bits > OFFSET_BITS + 1) ? coord_bits : OFFSET_BITS + 1) + 1;
    endfunction

    // table write broadcast to every cell
    typedef struct packed {
        logic                  vert_we;
        logic                  color_we;
        logic [TRI_BITS-1:0]   tri_sel;
        logic [SLOT_BITS-1:0]  slot;
        logic [COLOR_BITS-1:0] color;
    } fhtc_load_t;

    // first-hit record handed down the chain
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [HIT_BITS-1:0]   index;
        logic [COLOR_BITS-1:0] color;
    } fhtc_rec_t;

endpackage

`default_nettype wire

// File: hdl/fhtc_cell.sv
`default_nettype none

module fhtc_cell #(
    parameter int CELL_INDEX = 0,
    parameter int COORD_BITS = fhtc_pkg::DEFAULT_COORD_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fhtc_pkg::fhtc_load_t                load,
    input  wire logic signed [COORD_BITS-1:0]        load_x,
    input  wire logic signed [COORD_BITS-1:0]        load_y,
    input  wire logic [fhtc_pkg::COUNT_BITS-1:0]     tri_count,
    input  wire logic                                pt_valid_in,
    input  wire logic signed [fhtc_pkg::point_bits(COORD_BITS)-1:0] pt_u_in,
    input  wire logic signed [fhtc_pkg::point_bits(COORD_BITS)-1:0] pt_v_in,
    output logic                                     pt_valid_out,
    output logic signed [fhtc_pkg::point_bits(COORD_BITS)-1:0]      pt_u_out,
    output logic signed [fhtc_pkg::point_bits(COORD_BITS)-1:0]      pt_v_out,
    input  wire fhtc_pkg::fhtc_rec_t                 rec_in,
    output fhtc_pkg::fhtc_rec_t                      rec_out
);
    import fhtc_pkg::*;

    localparam int QW = point_bits(COORD_BITS);  // centered point
    localparam int DW = QW + 1;                  // point minus vertex
    localparam int EW = COORD_BITS + 1;          // edge vector
    localparam int PW = DW + EW;                 // product
    localparam int XW = PW + 1;                  // cross product
    localparam int SW = XW + 2;                  // sum of three areas

    // triangle held by this cell
    logic signed [COORD_BITS-1:0] x_reg [3];
    logic signed [COORD_BITS-1:0] y_reg [3];
    logic [COLOR_BITS-1:0]        color_reg;

    logic tri_match;
    logic enabled;

    // point stage
    logic                 pt_valid_reg;
    logic signed [QW-1:0] u_reg, v_reg;

    // difference stage
    logic                 s1_valid_reg;
    logic signed [DW-1:0] du0_reg, dv0_reg, du1_reg, dv1_reg;
    logic signed [EW-1:0] ex01_reg, ey01_reg, ex12_reg, ey12_reg, ex02_reg, ey02_reg;

    // product stage
    logic                 s2_valid_reg;
    logic signed [PW-1:0] p0a_reg, p0b_reg, p1a_reg, p1b_reg;
    logic signed [PW-1:0] p2a_reg, p2b_reg, pwa_reg, pwb_reg;

    // cross and abs stage
    logic                 s3_valid_reg;
    logic signed [XW-1:0] c0, c1, c2, cw;
    logic [XW-1:0]        a0_next, a1_next, a2_next, aw_next;
    logic [XW-1:0]        a0_reg, a1_reg, a2_reg, aw_reg;

    // compare and record stage
    logic [SW-1:0]        area_sum;
    logic                 hit;
    fhtc_rec_t            rec_next, rec_reg;

    assign tri_match = (int'(load.tri_sel) == CELL_INDEX);
    assign enabled   = (CELL_INDEX < int'(tri_count));

    always_ff @(posedge clk)
    begin
        if (load.vert_we && tri_match)
        begin
            x_reg[load.slot] <= load_x;
            y_reg[load.slot] <= load_y;
        end
        if (load.color_we && tri_match)
        begin
            color_reg <= load.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            rec_reg      <= '0;
        end
        else
        begin
            pt_valid_reg <= pt_valid_in;
            s1_valid_reg <= pt_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            rec_reg      <= rec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= pt_u_in;
        v_reg    <= pt_v_in;

        du0_reg  <= DW'(u_reg) - DW'(x_reg[0]);
        dv0_reg  <= DW'(v_reg) - DW'(y_reg[0]);
        du1_reg  <= DW'(u_reg) - DW'(x_reg[1]);
        dv1_reg  <= DW'(v_reg) - DW'(y_reg[1]);
        ex01_reg <= EW'(x_reg[1]) - EW'(x_reg[0]);
        ey01_reg <= EW'(y_reg[1]) - EW'(y_reg[0]);
        ex12_reg <= EW'(x_reg[2]) - EW'(x_reg[1]);
        ey12_reg <= EW'(y_reg[2]) - EW'(y_reg[1]);
        ex02_reg <= EW'(x_reg[2]) - EW'(x_reg[0]);
        ey02_reg <= EW'(y_reg[2]) - EW'(y_reg[0]);

        p0a_reg  <= PW'(ex01_reg) * PW'(dv0_reg);
        p0b_reg  <= PW'(ey01_reg) * PW'(du0_reg);
        p1a_reg  <= PW'(ex12_reg) * PW'(dv1_reg);
        p1b_reg  <= PW'(ey12_reg) * PW'(du1_reg);
        p2a_reg  <= PW'(ex02_reg) * PW'(dv0_reg);
        p2b_reg  <= PW'(ey02_reg) * PW'(du0_reg);
        pwa_reg  <= PW'(ex01_reg) * PW'(ey02_reg);
        pwb_reg  <= PW'(ey01_reg) * PW'(ex02_reg);

        a0_reg   <= a0_next;
        a1_reg   <= a1_next;
        a2_reg   <= a2_next;
        aw_reg   <= aw_next;
    end

    always_comb
    begin
        c0 = XW'(p0a_reg) - XW'(p0b_reg);
        c1 = XW'(p1a_reg) - XW'(p1b_reg);
        c2 = XW'(p2a_reg) - XW'(p2b_reg);
        cw = XW'(pwa_reg) - XW'(pwb_reg);
        a0_next = c0[XW-1] ? XW'(-c0) : XW'(c0);
        a1_next = c1[XW-1] ? XW'(-c1) : XW'(c1);
        a2_next = c2[XW-1] ? XW'(-c2) : XW'(c2);
        aw_next = cw[XW-1] ? XW'(-cw) : XW'(cw);
    end

    // edges count as inside: sub-areas add up to the whole exactly
    always_comb
    begin
        area_sum = SW'(a0_reg) + SW'(a1_reg) + SW'(a2_reg);
        hit      = s3_valid_reg && enabled && (area_sum == SW'(aw_reg));
        rec_next = '0;
        if (s3_valid_reg)
        begin
            if (rec_in.found)
            begin
                rec_next = rec_in;
            end
            else if (hit)
            begin
                rec_next.found = 1'b1;
                rec_next.index = HIT_BITS'(CELL_INDEX);
                rec_next.color = color_reg;
            end
            rec_next.valid = 1'b1;
        end
    end

    assign pt_valid_out = pt_valid_reg;
    assign pt_u_out     = u_reg;
    assign pt_v_out     = v_reg;
    assign rec_out      = rec_reg;

endmodule

`default_nettype wire

// File: hdl/first_hit_triangle_coverage_unit.sv
`default_nettype none

// a query transfer gives its result at the end of the chain of one cell per triangle,
//   each cell holding the four-stage area test
// one query at a time: busy refuses every transfer until the result strobe;
//   vertex and color loads do not raise busy and give no result
// the receiver cannot stall: done is a one-cycle strobe with the result beside it
// reset: center_offset 250, triangles_in_use 6, no query in flight; tables undefined
module first_hit_triangle_coverage_unit #(
    parameter int MAX_TRIANGLES = fhtc_pkg::DEFAULT_MAX_TRIANGLES,
    parameter int COORD_BITS    = fhtc_pkg::DEFAULT_COORD_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    // item command channel
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [fhtc_pkg::OP_BITS-1:0]          operation,
    input  wire logic [fhtc_pkg::TRI_BITS-1:0]         tri_index,
    input  wire logic [fhtc_pkg::SLOT_BITS-1:0]        vertex_slot,
    input  wire logic signed [COORD_BITS-1:0]          point_x,
    input  wire logic signed [COORD_BITS-1:0]          point_y,
    input  wire logic [fhtc_pkg::CHAN_BITS-1:0]        red_in,
    input  wire logic [fhtc_pkg::CHAN_BITS-1:0]        green_in,
    input  wire logic [fhtc_pkg::CHAN_BITS-1:0]        blue_in,

    // result strobe
    output logic                                       done,
    output logic                                       covered,
    output logic [fhtc_pkg::HIT_BITS-1:0]              hit_index,
    output logic [fhtc_pkg::CHAN_BITS-1:0]             red_out,
    output logic [fhtc_pkg::CHAN_BITS-1:0]             green_out,
    output logic [fhtc_pkg::CHAN_BITS-1:0]             blue_out,

    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fhtc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [fhtc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import fhtc_pkg::*;

    localparam int QW          = point_bits(COORD_BITS);
    localparam int BUSY_CYCLES = MAX_TRIANGLES + 3;   // busy drops in the strobe cycle
    localparam int LATENCY     = MAX_TRIANGLES + 4;
    localparam int CNT_BITS    = $clog2(BUSY_CYCLES + 1);

    // configuration registers
    logic [OFFSET_BITS-1:0] center_offset_reg;
    logic [COUNT_BITS-1:0]  tris_in_use_reg;

    // in-flight counter for the running query
    logic [CNT_BITS-1:0]    busy_cnt_reg, busy_cnt_next;

    logic                   accept;
    logic                   accept_query;
    fhtc_load_t             load;
    logic signed [QW-1:0]   offset_s;

    // chain links: entry k feeds cell k, cell k drives entry k+1
    logic                   pt_valid [MAX_TRIANGLES+1];
    logic signed [QW-1:0]   pt_u     [MAX_TRIANGLES+1];
    logic signed [QW-1:0]   pt_v     [MAX_TRIANGLES+1];
    fhtc_rec_t              rec      [MAX_TRIANGLES+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_offset_reg <= CENTER_OFFSET_RESET;
            tris_in_use_reg   <= TRIS_IN_USE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_OFFSET: center_offset_reg <= cfg_data[OFFSET_BITS-1:0];
                REG_TRIS_IN_USE:   tris_in_use_reg   <= cfg_data[COUNT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // a transfer happens whenever start meets a free block
    assign accept       = start && !busy;
    assign accept_query = accept && (operation == OP_QUERY);

    // loads go straight into the addressed cell; bad slot and unused opcode write nothing
    always_comb
    begin
        load          = '0;
        load.tri_sel  = tri_index;
        load.slot     = vertex_slot;
        load.color    = {blue_in, green_in, red_in};
        load.vert_we  = accept && (operation == OP_LOAD_VERTEX) && (vertex_slot != SLOT_UNUSED);
        load.color_we = accept && (operation == OP_LOAD_COLOR);
    end

    always_comb
    begin
        if (accept_query)
        begin
            busy_cnt_next = CNT_BITS'(BUSY_CYCLES);
        end
        else if (busy_cnt_reg != '0)
        begin
            busy_cnt_next = busy_cnt_reg - 1'b1;
        end
        else
        begin
            busy_cnt_next = busy_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_cnt_reg <= '0;
        end
        else
        begin
            busy_cnt_reg <= busy_cnt_next;
        end
    end

    assign busy = (busy_cnt_reg != '0);

    // centered point: u = column - offset, v = offset - row
    assign offset_s    = QW'(signed'({1'b0, center_offset_reg}));
    assign pt_valid[0] = accept_query;
    assign pt_u[0]     = QW'(point_x) - offset_s;
    assign pt_v[0]     = offset_s - QW'(point_y);
    assign rec[0]      = '0;

    // one cell per table entry; the point steps one cell per cycle and the
    // first-hit record trails it, so earlier hits win
    for (genvar k = 0; k < MAX_TRIANGLES; k++)
    begin : g_cell
        fhtc_cell #(
            .CELL_INDEX (k),
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .load         (load),
            .load_x       (point_x),
            .load_y       (point_y),
            .tri_count    (tris_in_use_reg),
            .pt_valid_in  (pt_valid[k]),
            .pt_u_in      (pt_u[k]),
            .pt_v_in      (pt_v[k]),
            .pt_valid_out (pt_valid[k+1]),
            .pt_u_out     (pt_u[k+1]),
            .pt_v_out     (pt_v[k+1]),
            .rec_in       (rec[k]),
            .rec_out      (rec[k+1])
        );
    end

    // the last cell's record register is the output register
    assign done      = rec[MAX_TRIANGLES].valid;
    assign covered   = rec[MAX_TRIANGLES].found;
    assign hit_index = rec[MAX_TRIANGLES].index;
    assign red_out   = rec[MAX_TRIANGLES].color[CHAN_BITS-1:0];
    assign green_out = rec[MAX_TRIANGLES].color[2*CHAN_BITS-1:CHAN_BITS];
    assign blue_out  = rec[MAX_TRIANGLES].color[3*CHAN_BITS-1:2*CHAN_BITS];

`ifndef SYNTHESIS
    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept_query |-> ##LATENCY done)
        else $error("query result missing at fixed latency");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result strobe");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation != OP_QUERY)) |=> !busy)
        else $error("load transfer made the block busy");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !covered) |-> ((hit_index == '0) && (red_out == '0)
                                && (green_out == '0) && (blue_out == '0)))
        else $error("miss result with nonzero fields");

    a_covered_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        covered |-> done)
        else $error("covered set outside a result strobe");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import fhtc_pkg::*;

    localparam int MAX_TRIS     = DEFAULT_MAX_TRIANGLES;
    localparam int CRD_BITS     = DEFAULT_COORD_BITS;
    localparam int CRD_MIN      = -(1 << (CRD_BITS - 1));
    localparam int CRD_MAX      = (1 << (CRD_BITS - 1)) - 1;
    // wait twice the time a query transfer takes to come back
    localparam int SETTLE_CYCLES = 2 * (MAX_TRIS + 4);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 62;

    // operation code that the block ignores
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    // one command transfer
    typedef struct packed {
        logic [OP_BITS-1:0]           op;
        logic [TRI_BITS-1:0]          tri_idx;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [CRD_BITS-1:0]   x;
        logic signed [CRD_BITS-1:0]   y;
        logic [CHAN_BITS-1:0]         red;
        logic [CHAN_BITS-1:0]         green;
        logic [CHAN_BITS-1:0]         blue;
    } pixel_cmd_t;

    // one coverage answer
    typedef struct packed {
        logic                  covered;
        logic [HIT_BITS-1:0]   hit;
        logic [CHAN_BITS-1:0]  red;
        logic [CHAN_BITS-1:0]  green;
        logic [CHAN_BITS-1:0]  blue;
    } coverage_t;

    // directed script line: a register write or a command, with an optional typed answer
    typedef struct packed {
        logic                      is_cfg;
        logic [CFG_IDX_BITS-1:0]   cfg_idx;
        logic [CFG_DATA_BITS-1:0]  cfg_val;
        pixel_cmd_t                cmd;
        logic                      has_want;
        coverage_t                 want;
    } script_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [OP_BITS-1:0]           operation;
    logic [TRI_BITS-1:0]          tri_index;
    logic [SLOT_BITS-1:0]         vertex_slot;
    logic signed [CRD_BITS-1:0]   point_x;
    logic signed [CRD_BITS-1:0]   point_y;
    logic [CHAN_BITS-1:0]         red_in;
    logic [CHAN_BITS-1:0]         green_in;
    logic [CHAN_BITS-1:0]         blue_in;
    logic                         done;
    logic                         covered;
    logic [HIT_BITS-1:0]          hit_index;
    logic [CHAN_BITS-1:0]         red_out;
    logic [CHAN_BITS-1:0]         green_out;
    logic [CHAN_BITS-1:0]         blue_out;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [CFG_IDX_BITS-1:0]      cfg_index;
    logic [CFG_DATA_BITS-1:0]     cfg_data;

    // shadow copy of the registers and the triangle table
    logic [OFFSET_BITS-1:0]       shadow_offset;
    logic [COUNT_BITS-1:0]        shadow_in_use;
    logic signed [CRD_BITS-1:0]   shadow_vx [MAX_TRIS][3];
    logic signed [CRD_BITS-1:0]   shadow_vy [MAX_TRIS][3];
    logic [CHAN_BITS-1:0]         shadow_red [MAX_TRIS];
    logic [CHAN_BITS-1:0]         shadow_green [MAX_TRIS];
    logic [CHAN_BITS-1:0]         shadow_blue [MAX_TRIS];

    // answers owed by the block, oldest first
    coverage_t     pending_answers [$];
    script_row_t   script [$];

    int errors;
    int cycle_count;
    int n_queries;
    int n_hits;
    int n_loads;
    int n_reg_writes;

    first_hit_triangle_coverage_unit #(
        .MAX_TRIANGLES (MAX_TRIS),
        .COORD_BITS    (CRD_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .tri_index   (tri_index),
        .vertex_slot (vertex_slot),
        .point_x     (point_x),
        .point_y     (point_y),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .done        (done),
        .covered     (covered),
        .hit_index   (hit_index),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // doubled triangle area, sign dropped
    function automatic longint doubled_area(input longint ax, input longint ay,
                                            input longint bx, input longint by,
                                            input longint cx, input longint cy);
        longint t;
        t = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
        return (t < 0) ? -t : t;
    endfunction

    // first triangle in use whose three sub-areas add up to its own area
    function automatic coverage_t predict_coverage(input pixel_cmd_t cmd);
        coverage_t  ans;
        longint     u;
        longint     v;
        longint     px [3];
        longint     py [3];
        longint     parts;
        int         n_use;
        bit         found;
        ans   = '0;
        found = 1'b0;
        // centered coordinates: column minus offset, offset minus row
        u = longint'($signed(cmd.x)) - longint'(shadow_offset);
        v = longint'(shadow_offset) - longint'($signed(cmd.y));
        n_use = (shadow_in_use > MAX_TRIS) ? MAX_TRIS : int'(shadow_in_use);
        for (int k = 0; k < n_use; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                px[j] = longint'(shadow_vx[k][j]);
                py[j] = longint'(shadow_vy[k][j]);
            end
            parts = doubled_area(px[0], py[0], px[1], py[1], u, v)
                  + doubled_area(px[1], py[1], px[2], py[2], u, v)
                  + doubled_area(px[0], py[0], px[2], py[2], u, v);
            if (!found && parts == doubled_area(px[0], py[0], px[1], py[1], px[2], py[2]))
            begin
                found       = 1'b1;
                ans.covered = 1'b1;
                ans.hit     = k[HIT_BITS-1:0];
                ans.red     = shadow_red[k];
                ans.green   = shadow_green[k];
                ans.blue    = shadow_blue[k];
            end
        end
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic void add_cmd(input logic [OP_BITS-1:0] op,
                                    input logic [TRI_BITS-1:0] t,
                                    input logic [SLOT_BITS-1:0] s,
                                    input logic signed [CRD_BITS-1:0] x,
                                    input logic signed [CRD_BITS-1:0] y,
                                    input logic [CHAN_BITS-1:0] r,
                                    input logic [CHAN_BITS-1:0] g,
                                    input logic [CHAN_BITS-1:0] b);
        script_row_t row;
        row             = '0;
        row.cmd.op      = op;
        row.cmd.tri_idx = t;
        row.cmd.slot    = s;
        row.cmd.x       = x;
        row.cmd.y       = y;
        row.cmd.red     = r;
        row.cmd.green   = g;
        row.cmd.blue    = b;
        script.push_back(row);
    endfunction

    // query whose answer is typed in here instead of predicted
    function automatic void add_known_query(input logic signed [CRD_BITS-1:0] col,
                                            input logic signed [CRD_BITS-1:0] row_y,
                                            input logic c,
                                            input logic [HIT_BITS-1:0] h,
                                            input logic [CHAN_BITS-1:0] r,
                                            input logic [CHAN_BITS-1:0] g,
                                            input logic [CHAN_BITS-1:0] b);
        add_cmd(OP_QUERY, 3'd0, 2'd0, col, row_y, 8'd0, 8'd0, 8'd0);
        script[$].has_want      = 1'b1;
        script[$].want.covered  = c;
        script[$].want.hit      = h;
        script[$].want.red      = r;
        script[$].want.green    = g;
        script[$].want.blue     = b;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
        script_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        script.push_back(row);
    endfunction

    // mostly a window around the origin, sometimes any 12-bit value
    function automatic logic signed [CRD_BITS-1:0] random_coord();
        if ($urandom_range(0, 3) != 0)
            return CRD_BITS'($urandom_range(0, 1400) - 700);
        return CRD_BITS'($urandom);
    endfunction

    function automatic pixel_cmd_t random_cmd();
        pixel_cmd_t  c;
        int          roll;
        int          n_use;
        int          k;
        int          j;
        longint      u;
        longint      v;
        longint      col;
        longint      row_y;
        c.tri_idx = TRI_BITS'($urandom_range(0, MAX_TRIS - 1));
        c.slot    = SLOT_BITS'($urandom_range(0, 2));
        c.x       = random_coord();
        c.y       = random_coord();
        c.red     = CHAN_BITS'($urandom);
        c.green   = CHAN_BITS'($urandom);
        c.blue    = CHAN_BITS'($urandom);
        roll      = $urandom_range(0, 99);
        if (roll < 24)
        begin
            c.op = OP_LOAD_VERTEX;
            if ($urandom_range(0, 19) == 0)
                c.slot = SLOT_UNUSED;
        end
        else if (roll < 32)
            c.op = OP_LOAD_COLOR;
        else if (roll < 35)
        begin
            c.op = OP_UNUSED;
            c.slot = SLOT_BITS'($urandom);
        end
        else
        begin
            c.op  = OP_QUERY;
            n_use = (shadow_in_use > MAX_TRIS) ? MAX_TRIS : int'(shadow_in_use);
            // most queries aim at a corner, a point near a corner, an edge middle or the centroid of a live triangle
            if (n_use > 0 && $urandom_range(0, 99) < 65)
            begin
                k = $urandom_range(0, n_use - 1);
                j = $urandom_range(0, 2);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        u = shadow_vx[k][j];
                        v = shadow_vy[k][j];
                    end
                    1:
                    begin
                        u = (longint'(shadow_vx[k][j]) + shadow_vx[k][(j + 1) % 3]) / 2;
                        v = (longint'(shadow_vy[k][j]) + shadow_vy[k][(j + 1) % 3]) / 2;
                    end
                    2:
                    begin
                        u = (longint'(shadow_vx[k][0]) + shadow_vx[k][1] + shadow_vx[k][2]) / 3;
                        v = (longint'(shadow_vy[k][0]) + shadow_vy[k][1] + shadow_vy[k][2]) / 3;
                    end
                    default:
                    begin
                        u = longint'(shadow_vx[k][j]) + $urandom_range(0, 2) - 1;
                        v = longint'(shadow_vy[k][j]) + $urandom_range(0, 2) - 1;
                    end
                endcase
                col   = u + shadow_offset;
                row_y = longint'(shadow_offset) - v;
                // keep the random point if the aimed one does not fit the port
                if (col >= CRD_MIN && col <= CRD_MAX && row_y >= CRD_MIN && row_y <= CRD_MAX)
                begin
                    c.x = CRD_BITS'(col);
                    c.y = CRD_BITS'(row_y);
                end
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one command transfer; on acceptance the shadow table or the answer queue moves
    task automatic issue_cmd(input pixel_cmd_t cmd, input bit gaps,
                             input bit has_want, input coverage_t want);
        if (gaps && $urandom_range(0, 99) < 38)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= cmd.op;
        tri_index   <= cmd.tri_idx;
        vertex_slot <= cmd.slot;
        point_x     <= cmd.x;
        point_y     <= cmd.y;
        red_in      <= cmd.red;
        green_in    <= cmd.green;
        blue_in     <= cmd.blue;
        do
            @(posedge clk);
        while (busy);
        // transfer taken at this edge
        if (cmd.op == OP_QUERY)
        begin
            pending_answers.push_back(has_want ? want : predict_coverage(cmd));
            n_queries++;
        end
        else if (cmd.op == OP_LOAD_VERTEX && cmd.slot != SLOT_UNUSED)
        begin
            shadow_vx[cmd.tri_idx][cmd.slot] = cmd.x;
            shadow_vy[cmd.tri_idx][cmd.slot] = cmd.y;
            n_loads++;
        end
        else if (cmd.op == OP_LOAD_COLOR)
        begin
            shadow_red[cmd.tri_idx]   = cmd.red;
            shadow_green[cmd.tri_idx] = cmd.green;
            shadow_blue[cmd.tri_idx]  = cmd.blue;
            n_loads++;
        end
    endtask

    // stop sending, let every owed answer arrive, then let trailing loads settle
    task automatic drain_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        drain_answers();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CENTER_OFFSET)
            shadow_offset = val[OFFSET_BITS-1:0];
        else
            shadow_in_use = val[COUNT_BITS-1:0];
        n_reg_writes++;
    endtask

    task automatic compare_field(input string what, input int want, input int seen);
        if (want != seen)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: done is a one-cycle strobe, taken at the edge that ends it
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : answer_check
        coverage_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                errors++;
                $display("%0t: result with no query waiting, actual covered %0d index %0d",
                         $time, covered, hit_index);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (covered)
                    n_hits++;
                compare_field("covered", want.covered, covered);
                compare_field("hit_index", want.hit, hit_index);
                compare_field("red_out", want.red, red_out);
                compare_field("green_out", want.green, green_out);
                compare_field("blue_out", want.blue, blue_out);
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [CFG_DATA_BITS-1:0]  ph_offset;
        logic [CFG_DATA_BITS-1:0]  ph_in_use;
        pixel_cmd_t                cmd;
        int                        taken;
        bit                        gaps;

        errors        = 0;
        cycle_count   = 0;
        n_queries     = 0;
        n_hits        = 0;
        n_loads       = 0;
        n_reg_writes  = 0;
        shadow_offset = CENTER_OFFSET_RESET;
        shadow_in_use = TRIS_IN_USE_RESET;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        operation   <= OP_LOAD_VERTEX;
        tri_index   <= '0;
        vertex_slot <= '0;
        point_x     <= '0;
        point_y     <= '0;
        red_in      <= '0;
        green_in    <= '0;
        blue_in     <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_CENTER_OFFSET;
        cfg_data    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table first so that no query reads an unwritten entry:
        // small right triangles in a row along the bottom of the coordinate range
        for (int k = 0; k < MAX_TRIS; k++)
        begin
            add_cmd(OP_LOAD_VERTEX, TRI_BITS'(k), 2'd0, CRD_BITS'(-2000 + 400 * k),
                    -2000, 8'd0, 8'd0, 8'd0);
            add_cmd(OP_LOAD_VERTEX, TRI_BITS'(k), 2'd1, CRD_BITS'(-1700 + 400 * k),
                    -2000, 8'd0, 8'd0, 8'd0);
            add_cmd(OP_LOAD_VERTEX, TRI_BITS'(k), 2'd2, CRD_BITS'(-2000 + 400 * k),
                    -1700, 8'd0, 8'd0, 8'd0);
            add_cmd(OP_LOAD_COLOR, TRI_BITS'(k), 2'd0, 0, 0, CHAN_BITS'(8'h20 * k),
                    CHAN_BITS'(8'hF0 - k), CHAN_BITS'(8'h0F + 8'h10 * k));
        end

        // triangle 0: right triangle with a corner on the origin
        add_cmd(OP_LOAD_VERTEX, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(OP_LOAD_VERTEX, 0, 1, 100, 0, 0, 0, 0);
        add_cmd(OP_LOAD_VERTEX, 0, 2, 0, 100, 0, 0, 0);
        add_cmd(OP_LOAD_COLOR, 0, 0, 0, 0, 8'h11, 8'h22, 8'h33);
        // reset offset 250 maps pixel (250, 250) onto the origin corner
        add_known_query(250, 250, 1'b1, 3'd0, 8'h11, 8'h22, 8'h33);
        add_cmd(OP_QUERY, 0, 0, 300, 250, 0, 0, 0);                 // on the bottom edge
        add_cmd(OP_QUERY, 0, 0, -2048, -2048, 0, 0, 0);
        add_cmd(OP_QUERY, 7, SLOT_UNUSED, 2047, 2047, 8'hFF, 8'hFF, 8'hFF);
        // bad slot and unused opcode must leave the table alone
        add_cmd(OP_LOAD_VERTEX, 0, SLOT_UNUSED, 2047, -2048, 0, 0, 0);
        add_cmd(OP_UNUSED, 7, SLOT_UNUSED, -1, -1, 8'hFF, 8'hFF, 8'hFF);
        add_known_query(250, 250, 1'b1, 3'd0, 8'h11, 8'h22, 8'h33);
        // triangle 1 collapsed onto the diagonal: zero area, segment counts as inside
        add_cmd(OP_LOAD_VERTEX, 1, 0, -2048, -2048, 0, 0, 0);
        add_cmd(OP_LOAD_VERTEX, 1, 1, 2047, 2047, 0, 0, 0);
        add_cmd(OP_LOAD_VERTEX, 1, 2, 0, 0, 0, 0, 0);
        add_cmd(OP_LOAD_COLOR, 1, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF);
        add_cmd(OP_QUERY, 0, 0, -250, 750, 0, 0, 0);                // on the segment
        add_cmd(OP_QUERY, 0, 0, -250, 749, 0, 0, 0);                // one row off it
        // offset extremes
        add_cfg(REG_CENTER_OFFSET, 0);
        add_known_query(0, 0, 1'b1, 3'd0, 8'h11, 8'h22, 8'h33);
        add_cfg(REG_CENTER_OFFSET, 1023);
        add_known_query(1023, 1023, 1'b1, 3'd0, 8'h11, 8'h22, 8'h33);
        // nothing in use always misses
        add_cfg(REG_TRIS_IN_USE, 0);
        add_known_query(1023, 1023, 1'b0, 3'd0, 8'd0, 8'd0, 8'd0);
        // count past the table size clamps to the full table; corner of triangle 7
        add_cfg(REG_CENTER_OFFSET, 0);
        add_cfg(REG_TRIS_IN_USE, 15);
        add_cmd(OP_QUERY, 0, 0, 800, 2000, 0, 0, 0);
        add_cfg(REG_TRIS_IN_USE, MAX_TRIS);
        add_cmd(OP_QUERY, 0, 0, 800, 2000, 0, 0, 0);
        add_cmd(OP_LOAD_VERTEX, 0, 0, -2048, 2047, 0, 0, 0);
        add_cmd(OP_LOAD_COLOR, 2, 0, 0, 0, 8'h00, 8'h00, 8'h00);
        add_cmd(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            else
                issue_cmd(script[i].cmd, 1'b1, script[i].has_want, script[i].want);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    ph_offset = 0;
                    ph_in_use = MAX_TRIS;
                end
                1:
                begin
                    ph_offset = 1023;
                    ph_in_use = 15;
                end
                2:
                begin
                    ph_offset = 250;
                    ph_in_use = 3;
                end
                4:
                begin
                    ph_offset = 512;
                    ph_in_use = 1;
                end
                default:
                begin
                    ph_offset = CFG_DATA_BITS'($urandom_range(0, 1023));
                    ph_in_use = CFG_DATA_BITS'($urandom_range(0, 15));
                end
            endcase
            write_reg(REG_CENTER_OFFSET, ph_offset);
            write_reg(REG_TRIS_IN_USE, ph_in_use);
            // phase 1 runs back to back with no sender gaps
            gaps  = (ph != 1);
            taken = 0;
            while (taken < PHASE_ITEMS)
            begin
                // once, hold the sender until the block has answered everything
                if (ph == 2 && taken == 10)
                    drain_answers();
                cmd = random_cmd();
                issue_cmd(cmd, gaps, 1'b0, '0);
                if (cmd.op != OP_UNUSED &&
                    !(cmd.op == OP_LOAD_VERTEX && cmd.slot == SLOT_UNUSED))
                    taken++;
            end
        end

        drain_answers();
        $display("checked %0d pixel queries (%0d covered) against %0d table loads",
                 n_queries, n_hits, n_loads);
        $display("over %0d register writes spanning offset and triangle count extremes",
                 n_reg_writes);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
